### rtl/core/dfs_pkg.sv
// Shared constants for the delimited field selector: register indexes, codes and defaults.
package dfs_pkg;

	// default width of the field counter
	localparam int FIELD_BITS_DEF = 16;

	// configuration port geometry
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;
	localparam int RANGE_COUNT    = 4;
	localparam int RANGE_HALF     = 16;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_DELIMITER  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WHITESPACE = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEEP_CHAR  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_0    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_1    = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_2    = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_3    = 3'd6;

	// character codes
	localparam logic [7:0] TAB_CODE     = 8'd9;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] CR_CODE      = 8'd13;
	localparam logic [7:0] SPACE_CODE   = 8'd32;

	// range end that means "to the end of the line"
	localparam logic [RANGE_HALF-1:0] RANGE_OPEN_END = 16'hFFFF;

	// register reset values
	localparam logic [7:0]               DELIMITER_RST = 8'd9;
	localparam logic [8:0]               KEEP_CHAR_RST = 9'd256;
	localparam logic [CFG_DATA_BITS-1:0] RANGE_0_RST   = 32'd1;
	localparam logic [CFG_DATA_BITS-1:0] RANGE_N_RST   = 32'd0;

endpackage

### rtl/core/delimited_field_selector.sv
// Delimited field selector: splits text lines into fields and passes the selected ones.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one beat per byte of a line, or a
//   line_end beat that closes the line. Output channel (out_valid/out_stall)
//   carries the selected field bytes, a tab before each further selected field,
//   and a newline with line_done set for every line_end beat.
//   Configuration (cfg_valid/cfg_ready) writes delimiter, whitespace mode, keep
//   character and four packed field ranges; write it only while the block is idle.
// Timing:
//   An accepted beat is held in the input stage, is decided there in one pass,
//   and its result (if any) is loaded into the output register as the beat
//   leaves the input stage.
//   Throughput is one beat per cycle while the output is not stalled, set by the
//   single decision stage that updates the field counter and line flags once per byte.
//   A beat that selects nothing frees its slot without a result.
// Reset:
//   arst_n clears both stages, the line state and loads the register defaults.
// Stall:
//   When out_stall holds a waiting result, the input stage holds its beat and
//   in_stall rises; nothing is dropped or repeated.
module delimited_field_selector #(
	parameter int FIELD_BITS = dfs_pkg::FIELD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input byte channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          char_code,
	input  logic                                line_end,
	// output byte channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          out_char,
	output logic                                line_done,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dfs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [dfs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int CMP_W = (FIELD_BITS > dfs_pkg::RANGE_HALF) ? FIELD_BITS : dfs_pkg::RANGE_HALF;
	localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

	// configuration registers
	logic [7:0]                        delim_q;
	logic                              ws_mode_q;
	logic [8:0]                        keep_char_q;
	logic [dfs_pkg::CFG_DATA_BITS-1:0] range_q [dfs_pkg::RANGE_COUNT];

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;

	// line state
	logic [FIELD_BITS-1:0] field_idx_q;
	logic                  line_start_q;
	logic                  keep_whole_q;
	logic                  has_out_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       line_done_q;

	// decision signals
	logic                  out_free;
	logic                  adv;
	logic                  keep_now;
	logic                  is_sep;
	logic [FIELD_BITS-1:0] idx_next;
	logic [FIELD_BITS-1:0] idx_used;
	logic                  sel;
	logic                  emit;
	logic [7:0]            emit_char;
	logic                  emit_done;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign line_done = line_done_q;

	// hand-off control: advance the input stage when the output slot is free
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// write configuration registers; ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q     <= dfs_pkg::DELIMITER_RST;
			ws_mode_q   <= 1'b0;
			keep_char_q <= dfs_pkg::KEEP_CHAR_RST;
			range_q[0]  <= dfs_pkg::RANGE_0_RST;
			range_q[1]  <= dfs_pkg::RANGE_N_RST;
			range_q[2]  <= dfs_pkg::RANGE_N_RST;
			range_q[3]  <= dfs_pkg::RANGE_N_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dfs_pkg::REG_DELIMITER:  delim_q     <= cfg_data[7:0];
				dfs_pkg::REG_WHITESPACE: ws_mode_q   <= cfg_data[0];
				dfs_pkg::REG_KEEP_CHAR:  keep_char_q <= cfg_data[8:0];
				dfs_pkg::REG_RANGE_0:    range_q[0]  <= cfg_data;
				dfs_pkg::REG_RANGE_1:    range_q[1]  <= cfg_data;
				dfs_pkg::REG_RANGE_2:    range_q[2]  <= cfg_data;
				dfs_pkg::REG_RANGE_3:    range_q[3]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture an input beat when the stage is empty or advancing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
			end_s1  <= line_end;
		end
	end

	// classify the held byte
	always_comb begin
		keep_now = line_start_q ? (!keep_char_q[8] && (char_s1 == keep_char_q[7:0]))
		                        : keep_whole_q;
		if (ws_mode_q) begin
			is_sep = (char_s1 == dfs_pkg::SPACE_CODE) ||
			         ((char_s1 >= dfs_pkg::TAB_CODE) && (char_s1 <= dfs_pkg::CR_CODE));
		end else begin
			is_sep = (char_s1 == delim_q);
		end
		idx_next = (field_idx_q != FIELD_MAX) ? field_idx_q + 1'b1 : field_idx_q;
		idx_used = is_sep ? idx_next : field_idx_q;
	end

	// test the field index against the union of the ranges
	always_comb begin
		logic [CMP_W-1:0] idx_w;
		logic [CMP_W-1:0] lo_w;
		logic [CMP_W-1:0] hi_w;
		logic             open_end;
		idx_w = CMP_W'(idx_used);
		sel   = 1'b0;
		for (int r = 0; r < dfs_pkg::RANGE_COUNT; r++) begin
			lo_w     = CMP_W'(range_q[r][31:16]);
			hi_w     = CMP_W'(range_q[r][15:0]);
			open_end = (range_q[r][15:0] == dfs_pkg::RANGE_OPEN_END);
			if ((idx_w >= lo_w) && (open_end || (idx_w < hi_w))) begin
				sel = 1'b1;
			end
		end
	end

	// decide the result of the held beat
	always_comb begin
		emit_done = 1'b0;
		emit_char = char_s1;
		priority if (end_s1) begin
			emit      = 1'b1;
			emit_char = dfs_pkg::NEWLINE_CODE;
			emit_done = 1'b1;
		end else if (keep_now) begin
			emit = 1'b1;
		end else if (is_sep) begin
			emit      = sel && has_out_q;
			emit_char = dfs_pkg::TAB_CODE;
		end else begin
			emit = sel;
		end
	end

	// advance the line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_idx_q  <= '0;
			line_start_q <= 1'b1;
			keep_whole_q <= 1'b0;
			has_out_q    <= 1'b0;
		end else if (adv) begin
			if (end_s1) begin
				field_idx_q  <= '0;
				line_start_q <= 1'b1;
				keep_whole_q <= 1'b0;
				has_out_q    <= 1'b0;
			end else begin
				line_start_q <= 1'b0;
				keep_whole_q <= keep_now;
				if (keep_now) begin
					has_out_q <= 1'b1;
				end else if (is_sep) begin
					field_idx_q <= idx_next;
				end else if (sel) begin
					has_out_q <= 1'b1;
				end
			end
		end
	end

	// load the output register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_char_q  <= emit_char;
			line_done_q <= emit_done;
		end
	end

	// checks on the line state and hand-off
	a_line_end_clears : assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |=> (field_idx_q == '0) && line_start_q && !has_out_q)
		else $error("line state not cleared after line end");

	a_index_monotonic : assert property (@(posedge clk) disable iff (!arst_n)
		adv && !end_s1 |=> field_idx_q >= $past(field_idx_q))
		else $error("field index went backwards within a line");

	a_stall_needs_beat : assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a held beat and blocked output");

	a_keep_after_start : assert property (@(posedge clk) disable iff (!arst_n)
		keep_whole_q |-> !line_start_q)
		else $error("keep flag set at line start");

	a_done_is_newline : assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |=> out_valid_q && line_done_q && (out_char_q == dfs_pkg::NEWLINE_CODE))
		else $error("line end did not produce a newline result");

endmodule
